/* sv/srpg_pkg.sv */
package srpg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int HALF_W      = 16;
    localparam int COUNT_W     = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HALF_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HALF_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENCODER_INC     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_INC        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_TICKS   = 3'd4;

    localparam logic [HALF_W-1:0]  RST_MIN_HALF_PERIOD = 16'd400;
    localparam logic [HALF_W-1:0]  RST_MAX_HALF_PERIOD = 16'd3000;
    localparam logic [HALF_W-1:0]  RST_ENCODER_INC     = 16'd100;
    localparam logic [HALF_W-1:0]  RST_RAMP_INC        = 16'd10;
    localparam logic [COUNT_W-1:0] RST_LOCKOUT_TICKS   = 20'd500000;

    typedef struct packed {
        logic rot_clk;
        logic rot_data;
        logic button_pressed;
    } srpg_in_t;

    typedef struct packed {
        logic              step_level;
        logic              driver_disabled;
        logic [HALF_W-1:0] current_half_period;
        logic [HALF_W-1:0] target_half_period;
    } srpg_out_t;

    // A half-period of zero is timed as a single tick.
    function automatic logic [COUNT_W-1:0] half_ticks(input logic [HALF_W-1:0] h);
        logic [COUNT_W-1:0] r;
        r = (h == '0) ? COUNT_W'(1) : COUNT_W'(h);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] dec_sat(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = (c != '0) ? c - COUNT_W'(1) : '0;
        return r;
    endfunction

endpackage

/* sv/stepper_ramp_pulse_generator.sv */
// Step pulse generator with an encoder-set target half-period and a linear ramp of the
// current half-period toward it. Every input beat is one microsecond tick and yields
// exactly one result beat carrying the step level for that tick and the state after it.
// The block takes one beat per clock cycle while the output is not stalled: all per-tick
// work (button toggle, encoder step with min/max clamp, ramp step, pulse timing) is done
// between the state registers and a single output register. While the output is stalled, the
// result is held and in_stall is raised; input is accepted again in the cycle the output
// frees up. Configuration writes are always ready and take effect on the next tick.
module stepper_ramp_pulse_generator
    import srpg_pkg::*;
#(
    parameter int START_PERIOD = 2000
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  srpg_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output srpg_out_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        PH_BOUNDARY,
        PH_HIGH,
        PH_LOW,
        PH_LOCK
    } phase_t;

    // Configuration registers.
    logic [HALF_W-1:0]  min_half_reg;
    logic [HALF_W-1:0]  max_half_reg;
    logic [HALF_W-1:0]  enc_inc_reg;
    logic [HALF_W-1:0]  ramp_inc_reg;
    logic [COUNT_W-1:0] lockout_reg;

    // Tick state.
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next, cnt_dec;
    logic [HALF_W-1:0]  cur_reg, cur_next;
    logic [HALF_W-1:0]  tgt_reg, tgt_next;
    logic               last_clk_reg, last_clk_next;
    logic               motor_on_reg, motor_on_next;
    logic               level;
    logic               start_period;

    logic               out_valid_reg;
    srpg_out_t          out_data_reg;
    logic               in_accept;

    // Period-start arithmetic, used only when a new pulse begins.
    logic signed [HALF_W+1:0] tgt_sum;
    logic signed [HALF_W+1:0] tgt_lo;
    logic signed [HALF_W+1:0] tgt_hi;
    logic [HALF_W-1:0]        tgt_clamped;
    logic [HALF_W-1:0]        begin_tgt;
    logic [HALF_W:0]          cur_up;
    logic [HALF_W-1:0]        cur_begin;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign tgt_sum = (in_data.rot_data != in_data.rot_clk)
                   ? $signed({2'b00, tgt_reg}) - $signed({2'b00, enc_inc_reg})
                   : $signed({2'b00, tgt_reg}) + $signed({2'b00, enc_inc_reg});
    assign tgt_lo  = (tgt_sum < $signed({2'b00, min_half_reg}))
                   ? $signed({2'b00, min_half_reg}) : tgt_sum;
    // The max clamp comes last, so it wins when min is above max.
    assign tgt_hi  = (tgt_lo > $signed({2'b00, max_half_reg}))
                   ? $signed({2'b00, max_half_reg}) : tgt_lo;
    assign tgt_clamped = tgt_hi[HALF_W-1:0];
    assign begin_tgt   = (in_data.rot_clk != last_clk_reg) ? tgt_clamped : tgt_reg;

    assign cur_up = {1'b0, cur_reg} + {1'b0, ramp_inc_reg};

    always_comb
    begin
        priority if (cur_reg < begin_tgt)
        begin
            cur_begin = cur_up[HALF_W] ? '1 : cur_up[HALF_W-1:0];
        end
        else if (cur_reg > begin_tgt)
        begin
            cur_begin = (cur_reg > ramp_inc_reg) ? cur_reg - ramp_inc_reg : '0;
        end
        else
        begin
            cur_begin = cur_reg;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        last_clk_next = last_clk_reg;
        motor_on_next = motor_on_reg;
        start_period  = 1'b0;
        level         = 1'b0;
        cnt_dec       = '0;

        unique case (phase_reg)
            PH_BOUNDARY:
            begin
                if (in_data.button_pressed)
                begin
                    motor_on_next = ~motor_on_reg;
                    if (lockout_reg != '0)
                    begin
                        phase_next = PH_LOCK;
                        cnt_next   = lockout_reg - COUNT_W'(1);
                    end
                    else
                    begin
                        start_period = 1'b1;
                    end
                end
                else
                begin
                    start_period = 1'b1;
                end
            end
            PH_LOCK:
            begin
                if (cnt_reg == '0)
                begin
                    start_period = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - COUNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (start_period)
        begin
            tgt_next      = begin_tgt;
            last_clk_next = in_data.rot_clk;
            cur_next      = cur_begin;
            phase_next    = PH_HIGH;
            cnt_next      = half_ticks(cur_begin);
        end

        // The tick that starts a pulse is already its first high tick.
        if (phase_next == PH_HIGH)
        begin
            level   = 1'b1;
            cnt_dec = dec_sat(cnt_next);
            if (cnt_dec == '0)
            begin
                phase_next = PH_LOW;
                cnt_next   = half_ticks(cur_next);
            end
            else
            begin
                cnt_next = cnt_dec;
            end
        end
        else if (phase_next == PH_LOW)
        begin
            cnt_dec  = dec_sat(cnt_next);
            cnt_next = cnt_dec;
            if (cnt_dec == '0)
            begin
                phase_next = PH_BOUNDARY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_half_reg  <= RST_MIN_HALF_PERIOD;
            max_half_reg  <= RST_MAX_HALF_PERIOD;
            enc_inc_reg   <= RST_ENCODER_INC;
            ramp_inc_reg  <= RST_RAMP_INC;
            lockout_reg   <= RST_LOCKOUT_TICKS;
            phase_reg     <= PH_BOUNDARY;
            cnt_reg       <= '0;
            cur_reg       <= HALF_W'(START_PERIOD);
            tgt_reg       <= HALF_W'(START_PERIOD);
            last_clk_reg  <= 1'b1;
            motor_on_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MIN_HALF_PERIOD: min_half_reg <= cfg_data[HALF_W-1:0];
                    CFG_MAX_HALF_PERIOD: max_half_reg <= cfg_data[HALF_W-1:0];
                    CFG_ENCODER_INC:     enc_inc_reg  <= cfg_data[HALF_W-1:0];
                    CFG_RAMP_INC:        ramp_inc_reg <= cfg_data[HALF_W-1:0];
                    CFG_LOCKOUT_TICKS:   lockout_reg  <= cfg_data[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_accept)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                cur_reg       <= cur_next;
                tgt_reg       <= tgt_next;
                last_clk_reg  <= last_clk_next;
                motor_on_reg  <= motor_on_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg.step_level          <= level;
            out_data_reg.driver_disabled     <= ~motor_on_next;
            out_data_reg.current_half_period <= cur_next;
            out_data_reg.target_half_period  <= tgt_next;
        end
    end

    // A running half-period always has ticks left; an expired one moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |-> (cnt_reg != '0))
        else $error("pulse phase held with an empty tick counter");

    // During a button lockout the last delivered tick has the step output low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && phase_reg == PH_LOCK) |-> !out_data_reg.step_level)
        else $error("step output high during button lockout");

    // Driver state in the result follows the internal enable flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.driver_disabled == !motor_on_reg))
        else $error("driver_disabled disagrees with enable state");

endmodule

/* tb/ramp_tracker_pkg.sv */
package ramp_tracker_pkg;
    import srpg_pkg::*;

    typedef enum logic [1:0] {
        AT_BOUNDARY,
        PULSE_HIGH,
        PULSE_LOW,
        LOCKED_OUT
    } pulse_stage_t;

    // Tracks the pulse timing, encoder target and ramp of the generator tick by
    // tick, and holds the result beats that the block still owes.
    class ramp_tracker;
        logic [HALF_W-1:0]  min_half;
        logic [HALF_W-1:0]  max_half;
        logic [HALF_W-1:0]  enc_step;
        logic [HALF_W-1:0]  ramp_step;
        logic [COUNT_W-1:0] lockout;

        pulse_stage_t       stage;
        logic [COUNT_W-1:0] countdown;
        logic [HALF_W-1:0]  cur_half;
        logic [HALF_W-1:0]  tgt_half;
        logic               last_clk;
        logic               drive_on;

        srpg_out_t          results_due[$];
        int unsigned        ticks_checked;
        int unsigned        bad_beats;

        function new(logic [HALF_W-1:0] start_half);
            min_half      = RST_MIN_HALF_PERIOD;
            max_half      = RST_MAX_HALF_PERIOD;
            enc_step      = RST_ENCODER_INC;
            ramp_step     = RST_RAMP_INC;
            lockout       = RST_LOCKOUT_TICKS;
            stage         = AT_BOUNDARY;
            countdown     = '0;
            cur_half      = start_half;
            tgt_half      = start_half;
            last_clk      = 1'b1;
            drive_on      = 1'b1;
            ticks_checked = 0;
            bad_beats     = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MIN_HALF_PERIOD: min_half = value[HALF_W-1:0];
                CFG_MAX_HALF_PERIOD: max_half = value[HALF_W-1:0];
                CFG_ENCODER_INC:     enc_step = value[HALF_W-1:0];
                CFG_RAMP_INC:        ramp_step = value[HALF_W-1:0];
                CFG_LOCKOUT_TICKS:   lockout = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COUNT_W-1:0] timed_half();
            return (cur_half == '0) ? COUNT_W'(1) : COUNT_W'(cur_half);
        endfunction

        function void start_period(logic clk_level, logic dt_level);
            int t;
            int c;
            if (clk_level != last_clk)
            begin
                t = int'(tgt_half);
                if (dt_level != clk_level)
                    t -= int'(enc_step);
                else
                    t += int'(enc_step);
                // The max clamp comes last, so it wins when min is above max.
                if (t < int'(min_half))
                    t = int'(min_half);
                if (t > int'(max_half))
                    t = int'(max_half);
                tgt_half = t[HALF_W-1:0];
            end
            last_clk = clk_level;

            if (cur_half < tgt_half)
            begin
                c = int'(cur_half) + int'(ramp_step);
                cur_half = (c > 65535) ? '1 : c[HALF_W-1:0];
            end
            else if (cur_half > tgt_half)
                cur_half = (cur_half > ramp_step) ? cur_half - ramp_step : '0;

            stage = PULSE_HIGH;
            countdown = timed_half();
        endfunction

        function void take_tick(srpg_in_t tick);
            srpg_out_t r;
            r.step_level = 1'b0;

            if (stage == AT_BOUNDARY)
            begin
                if (tick.button_pressed)
                begin
                    drive_on = ~drive_on;
                    if (lockout != '0)
                    begin
                        stage = LOCKED_OUT;
                        countdown = lockout - COUNT_W'(1);
                    end
                end
                if (stage == AT_BOUNDARY)
                    start_period(tick.rot_clk, tick.rot_data);
            end
            else if (stage == LOCKED_OUT)
            begin
                if (countdown == '0)
                    start_period(tick.rot_clk, tick.rot_data);
                else
                    countdown--;
            end

            if (stage == PULSE_HIGH)
            begin
                r.step_level = 1'b1;
                if (countdown != '0)
                    countdown--;
                if (countdown == '0)
                begin
                    stage = PULSE_LOW;
                    countdown = timed_half();
                end
            end
            else if (stage == PULSE_LOW)
            begin
                if (countdown != '0)
                    countdown--;
                if (countdown == '0)
                    stage = AT_BOUNDARY;
            end

            r.driver_disabled     = ~drive_on;
            r.current_half_period = cur_half;
            r.target_half_period  = tgt_half;
            results_due.push_back(r);
        endfunction

        function bit at_boundary();
            return stage == AT_BOUNDARY;
        endfunction

        function int unsigned outstanding();
            return results_due.size();
        endfunction

        function bit differs(string name, logic [HALF_W-1:0] want, logic [HALF_W-1:0] got);
            if (got === want)
                return 1'b0;
            if (bad_beats < 10)
                $display("beat %0d %s: expected %0d, got %0d", ticks_checked, name, want, got);
            return 1'b1;
        endfunction

        function void check_result(srpg_out_t got);
            srpg_out_t want;
            bit bad;
            if (results_due.size() == 0)
            begin
                if (bad_beats < 10)
                    $display("beat %0d arrived with no tick waiting for it", ticks_checked);
                bad_beats++;
                ticks_checked++;
                return;
            end
            want = results_due.pop_front();
            bad = 1'b0;
            bad |= differs("step_level", HALF_W'(want.step_level), HALF_W'(got.step_level));
            bad |= differs("driver_disabled", HALF_W'(want.driver_disabled),
                           HALF_W'(got.driver_disabled));
            bad |= differs("current_half_period", want.current_half_period,
                           got.current_half_period);
            bad |= differs("target_half_period", want.target_half_period,
                           got.target_half_period);
            if (bad)
                bad_beats++;
            ticks_checked++;
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srpg_pkg::*;
    import ramp_tracker_pkg::*;

    localparam int START_HALF = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    srpg_in_t               in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    srpg_out_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    ramp_tracker tracker = new(HALF_W'(START_HALF));

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned tx_idle_odds = 10;
    int unsigned stall_left = 0;
    logic        knob_clk = 1'b1;
    logic        knob_dt = 1'b1;

    stepper_ramp_pulse_generator #(
        .START_PERIOD(START_HALF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Encoder lines wander like a knob being turned; the button is pressed now and then.
    function srpg_in_t noise_tick();
        srpg_in_t t;
        if ($urandom_range(0, 3) == 0)
            knob_clk = ~knob_clk;
        if ($urandom_range(0, 3) == 0)
            knob_dt = ~knob_dt;
        t.rot_clk        = knob_clk;
        t.rot_data       = knob_dt;
        t.button_pressed = ($urandom_range(0, 5) == 0);
        return t;
    endfunction

    task automatic send_tick(input srpg_in_t tick);
        if (tx_idle_on && $urandom_range(1, tx_idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge clk); while (in_stall);
        tracker.take_tick(tick);
    endtask

    // Runs the pulse out with noise, then lands a chosen beat on the period boundary.
    task automatic tick_at_boundary(input bit turn, input bit ccw, input bit press);
        srpg_in_t t;
        while (!tracker.at_boundary())
            send_tick(noise_tick());
        t.rot_clk        = turn ? ~tracker.last_clk : tracker.last_clk;
        t.rot_data       = ccw ? ~t.rot_clk : t.rot_clk;
        t.button_pressed = press;
        send_tick(t);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, value);
    endtask

    task automatic program_regs(input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi,
                                input logic [HALF_W-1:0] enc, input logic [HALF_W-1:0] ramp,
                                input logic [COUNT_W-1:0] lock);
        in_valid <= 1'b0;
        // Every tick yields a beat, so an empty queue means the block is idle.
        while (tracker.outstanding() != 0)
            @(posedge clk);
        write_reg(CFG_MIN_HALF_PERIOD, CFG_DATA_W'(lo));
        write_reg(CFG_MAX_HALF_PERIOD, CFG_DATA_W'(hi));
        write_reg(CFG_ENCODER_INC, CFG_DATA_W'(enc));
        write_reg(CFG_RAMP_INC, CFG_DATA_W'(ramp));
        write_reg(CFG_LOCKOUT_TICKS, CFG_DATA_W'(lock));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                tracker.check_result(out_data);
            if (stall_left != 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 18);
                out_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Leave the clamps at reset: the first boundary steps the target below the reset minimum,
        // where it is clamped, and ramps the start half-period down to a single tick.
        write_reg(CFG_ENCODER_INC, CFG_DATA_W'(1700));
        write_reg(CFG_RAMP_INC, CFG_DATA_W'(1999));
        cfg_valid <= 1'b0;
        tick_at_boundary(1'b1, 1'b1, 1'b0);

        program_regs(16'd1, 16'd2, 16'd1, 16'd1, 20'd1);
        tick_at_boundary(1'b1, 1'b0, 1'b0);
        tick_at_boundary(1'b0, 1'b0, 1'b1);
        tick_at_boundary(1'b1, 1'b1, 1'b1);
        tick_at_boundary(1'b0, 1'b0, 1'b0);

        // Minimum above maximum, and button toggles with no lockout.
        program_regs(16'd3, 16'd2, 16'd1, 16'd2, 20'd0);
        tick_at_boundary(1'b1, 1'b0, 1'b1);
        tick_at_boundary(1'b1, 1'b1, 1'b1);

        // Ramp past zero: the half-period saturates at zero and is timed as one tick.
        program_regs(16'd1, 16'd1, 16'd1, 16'd7, 20'd0);
        tick_at_boundary(1'b1, 1'b1, 1'b0);
        tick_at_boundary(1'b0, 1'b0, 1'b0);

        for (int p = 0; p < 7; p++)
        begin
            if (p == 5)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            tx_idle_odds = $urandom_range(4, 30);
            program_regs(HALF_W'($urandom_range(1, 6)),
                         ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : HALF_W'($urandom_range(1, 12)),
                         ($urandom_range(0, 4) == 0) ? 16'hFFFF
                                                     : HALF_W'($urandom_range(1, 4)),
                         HALF_W'($urandom_range(1, 5)),
                         COUNT_W'($urandom_range(0, 5)));
            repeat (165) send_tick(noise_tick());
        end

        // All registers at their top values: the ramp saturates at the top and the
        // pulse runs long, so the button is kept off the boundary.
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        tick_at_boundary(1'b1, 1'b0, 1'b0);
        repeat (40) send_tick(noise_tick());

        in_valid <= 1'b0;
        for (int w = 0; w < 1000 && tracker.outstanding() != 0; w++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (tracker.outstanding() != 0)
        begin
            $display("%0d result beats never arrived", tracker.outstanding());
            tracker.bad_beats += tracker.outstanding();
        end

        if (tracker.bad_beats == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
sv/srpg_pkg.sv
sv/stepper_ramp_pulse_generator.sv
tb/ramp_tracker_pkg.sv
tb/tb_top.sv
